[design/softmax_defect_decision_top_assert.svh]
// ----------------------------------------------------------------------------
// softmax_defect_decision_top_assert.svh
// Assertion macros for the softmax defect decision RTL.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_DEFECT_DECISION_TOP_ASSERT_SVH
`define SOFTMAX_DEFECT_DECISION_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SDD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdd assertion failed");

// next-cycle implication, disabled in reset
`define SDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdd assertion failed");

`endif

[design/sdd_pkg.sv]
// ----------------------------------------------------------------------------
// sdd_pkg
// Types, constants and the exp(-d) table builder for the softmax defect
// decision block.
// ----------------------------------------------------------------------------
package sdd_pkg;

  // field widths
  localparam int NUM_CLASS_COUNT = 5;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int TAG_W      = 16;
  localparam int LOGIT_W    = 16;
  localparam int PROB_W     = 16;
  localparam int CLS_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int EXP_W     = 17;                        // table value, 65536 max
  localparam int IDX_W     = $clog2(EXP_TABLE_DEPTH);
  localparam int D_SPAN_W  = 12;                        // d below 16.0 in Q8.8
  localparam int PROD_W    = D_SPAN_W + IDX_W + 1;
  localparam int SUM_W     = 19;                        // five table values
  localparam int REM_W     = 20;                        // holds 2*sum
  localparam int QUO_W     = 18;                        // quotient bits, even count
  localparam int NUM_W     = 34;                        // e*2^16 + sum/2
  localparam int DIV_STEPS = QUO_W / 2;                 // two bits per cycle
  localparam int CNT_W     = 4;

  localparam logic [PROB_W-1:0] THRESHOLD_RST = 16'd32768;
  localparam logic [PROB_W-1:0] GUARD_RST     = 16'd52429;

  // class codes
  typedef enum logic [CLS_W-1:0] {
    CLS_CUTS,
    CLS_HOLE,
    CLS_LINT,
    CLS_NORMAL,
    CLS_OIL
  } cls_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFECT_THRESHOLD,
    REG_CONFIDENCE_GUARD
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MAX,
    S_EXP,
    S_DLOAD,
    S_DSTEP,
    S_DECIDE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load_in;
    logic             latch_max;
    logic             exp_rd;
    logic [CLS_W-1:0] rd_cls;
    logic             exp_wr;
    logic [CLS_W-1:0] wr_cls;
    logic             div_load;
    logic             div_step;
    logic             div_store;
    logic [CLS_W-1:0] cls;
    logic             decide;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic skip;
    logic out_free;
  } stat_t;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(-i*16/depth) in Q1.16, built through a Q0.32 ratio recurrence
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] v;
    s    = (64'd16 << 32) / EXP_TABLE_DEPTH;
    term = 64'd1 << 32;
    r    = term;
    v    = term;
    // nine-term series for exp(-s), each term truncated
    term = (term * s) >> 32;       r = r - term;
    term = ((term * s) >> 32) / 2; r = r + term;
    term = ((term * s) >> 32) / 3; r = r - term;
    term = ((term * s) >> 32) / 4; r = r + term;
    term = ((term * s) >> 32) / 5; r = r - term;
    term = ((term * s) >> 32) / 6; r = r + term;
    term = ((term * s) >> 32) / 7; r = r - term;
    term = ((term * s) >> 32) / 8; r = r + term;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) begin
        v = (v * r + (64'd1 << 31)) >> 32;
      end
      tab[i] = EXP_W'((v + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[design/sdd_in_if.sv]
// ----------------------------------------------------------------------------
// sdd_in_if
// Input channel: frame tag and five class logits per transaction.
// ----------------------------------------------------------------------------
interface sdd_in_if import sdd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [TAG_W-1:0]   frame_tag;
  logic signed [LOGIT_W-1:0] logit_cuts;
  logic signed [LOGIT_W-1:0] logit_hole;
  logic signed [LOGIT_W-1:0] logit_lint;
  logic signed [LOGIT_W-1:0] logit_normal;
  logic signed [LOGIT_W-1:0] logit_oil;

  modport source (
    output valid, frame_tag, logit_cuts, logit_hole, logit_lint, logit_normal, logit_oil,
    input  ready
  );
  modport sink (
    input  valid, frame_tag, logit_cuts, logit_hole, logit_lint, logit_normal, logit_oil,
    output ready
  );
endinterface

[design/sdd_out_if.sv]
// ----------------------------------------------------------------------------
// sdd_out_if
// Result channel: class decision for one region per transaction.
// ----------------------------------------------------------------------------
interface sdd_out_if import sdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  result_frame_tag;
  logic [CLS_W-1:0]  pred_class;
  logic [PROB_W-1:0] confidence;
  logic [PROB_W-1:0] defect_prob;
  logic              defect_flag;

  modport source (
    output valid, result_frame_tag, pred_class, confidence, defect_prob,
           defect_flag,
    input  ready
  );
  modport sink (
    input  valid, result_frame_tag, pred_class, confidence, defect_prob,
           defect_flag,
    output ready
  );
endinterface

[design/sdd_ctrl.sv]
// ----------------------------------------------------------------------------
// sdd_ctrl
// Sequencer: frame check, max search, table sweep, per-class division and
// the final decision.
// ----------------------------------------------------------------------------
`include "softmax_defect_decision_top_assert.svh"

module sdd_ctrl import sdd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cls_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cls_r   <= cls_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cls_nxt   = cls_r;
    cmd       = '0;
    cmd.cls   = cls_r;
    cmd.rd_cls = cnt_r[CLS_W-1:0];
    cmd.wr_cls = CLS_W'(cnt_r - CNT_W'(1));
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no transaction is taken while reset is held
        in_ready    = rst_n;
        cmd.load_in = in_valid && rst_n;
        if (in_valid && rst_n) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // frame already flagged: drop the region
        state_nxt = stat.skip ? S_IDLE : S_MAX;
      end
      S_MAX: begin
        cmd.latch_max = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_EXP;
      end
      S_EXP: begin
        // table read for class cnt, capture for class cnt-1
        cmd.exp_rd = (cnt_r < CNT_W'(NUM_CLASS_COUNT));
        cmd.exp_wr = (cnt_r != '0);
        if (cnt_r == CNT_W'(NUM_CLASS_COUNT)) begin
          cls_nxt   = '0;
          state_nxt = S_DLOAD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_store = 1'b1;
          if (cls_r == CLS_W'(NUM_CLASS_COUNT - 1)) begin
            state_nxt = S_DECIDE;
          end else begin
            cls_nxt   = cls_r + CLS_W'(1);
            state_nxt = S_DLOAD;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // assertions
  `SDD_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state_r == S_CHECK)
  `SDD_ASSERT_IMPL(a_step_bound, state_r == S_DSTEP, cnt_r < CNT_W'(DIV_STEPS))
  `SDD_ASSERT_IMPL(a_decide_room, cmd.decide, stat.out_free)
  `SDD_ASSERT_IMPL(a_one_phase, 1'b1, $onehot0({cmd.load_in, cmd.latch_max, cmd.div_load, cmd.div_step, cmd.decide}))

endmodule

[design/sdd_datapath.sv]
// ----------------------------------------------------------------------------
// sdd_datapath
// Logit store, exp table ROM, radix-4 restoring divider, argmax and the
// defect decision with its frame state and output register.
// ----------------------------------------------------------------------------
module sdd_datapath import sdd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic        [TAG_W-1:0]   in_frame_tag,
  input  logic signed [LOGIT_W-1:0] in_logit [NUM_CLASS_COUNT],
  input  logic                      cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  sdd_out_if.source                 out_ch
);

  // configuration and frame state
  logic [PROB_W-1:0] thr_r;
  logic [PROB_W-1:0] guard_r;
  logic              flagged_r;
  logic [TAG_W-1:0]  last_tag_r;

  // item payload
  logic        [TAG_W-1:0]   tag_r;
  logic signed [LOGIT_W-1:0] logit_r [NUM_CLASS_COUNT];
  logic signed [LOGIT_W-1:0] mx_r;
  logic        [EXP_W-1:0]   rom_q_r;
  logic                      zero_q_r;
  logic        [EXP_W-1:0]   e_r [NUM_CLASS_COUNT];
  logic        [SUM_W-1:0]   sum_r;
  logic        [EXP_W-1:0]   p_r [NUM_CLASS_COUNT];

  // divider
  logic [REM_W-1:0] rem_r;
  logic [QUO_W-1:0] num_r;
  logic [QUO_W-1:0] quo_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]  o_tag_r;
  logic [CLS_W-1:0]  o_cls_r;
  logic [PROB_W-1:0] o_conf_r;
  logic [PROB_W-1:0] o_dsum_r;
  logic              o_flag_r;

  // max over the five logits, first wins
  logic signed [LOGIT_W-1:0] mx_w;
  always_comb begin
    mx_w = logit_r[0];
    for (int k = 1; k < NUM_CLASS_COUNT; k++) begin
      if (logit_r[k] > mx_w) begin
        mx_w = logit_r[k];
      end
    end
  end

  // table index for the class being read
  logic signed [LOGIT_W:0] diff_w;
  logic                    d_big_w;
  logic [PROD_W-1:0]       prod_w;
  logic [PROD_W-1:0]       idx_full_w;
  logic [IDX_W-1:0]        rd_idx_w;
  always_comb begin
    diff_w     = LOGIT_W'(0) + ($signed({mx_r[LOGIT_W-1], mx_r}) -
                 $signed({logit_r[cmd.rd_cls][LOGIT_W-1], logit_r[cmd.rd_cls]}));
    d_big_w    = |diff_w[LOGIT_W:D_SPAN_W];
    prod_w     = PROD_W'(diff_w[D_SPAN_W-1:0]) * PROD_W'(EXP_TABLE_DEPTH);
    idx_full_w = prod_w >> D_SPAN_W;
    if (idx_full_w >= PROD_W'(EXP_TABLE_DEPTH)) begin
      idx_full_w = PROD_W'(EXP_TABLE_DEPTH - 1);
    end
    rd_idx_w = idx_full_w[IDX_W-1:0];
  end

  // table value that lands this cycle
  logic [EXP_W-1:0] e_new_w;
  assign e_new_w = zero_q_r ? '0 : rom_q_r;

  // divider operands
  logic [SUM_W-1:0] sum_eff_w;
  logic [NUM_W-1:0] num_full_w;
  assign sum_eff_w  = (sum_r == '0) ? SUM_W'(1) : sum_r;
  assign num_full_w = NUM_W'({e_r[cmd.cls], 16'b0}) + NUM_W'(sum_eff_w[SUM_W-1:1]);

  // two restoring steps per cycle
  logic [REM_W-1:0] r1_w, r1s_w, r2_w, r2s_w;
  logic             ge1_w, ge2_w;
  logic [QUO_W-1:0] quo_nxt;
  always_comb begin
    r1_w    = {rem_r[REM_W-2:0], num_r[QUO_W-1]};
    ge1_w   = (r1_w >= REM_W'(sum_eff_w));
    r1s_w   = ge1_w ? r1_w - REM_W'(sum_eff_w) : r1_w;
    r2_w    = {r1s_w[REM_W-2:0], num_r[QUO_W-2]};
    ge2_w   = (r2_w >= REM_W'(sum_eff_w));
    r2s_w   = ge2_w ? r2_w - REM_W'(sum_eff_w) : r2_w;
    quo_nxt = {quo_r[QUO_W-3:0], ge1_w, ge2_w};
  end

  // argmax, confidence, defect sum and decision
  logic [CLS_W-1:0]  best_w;
  logic [EXP_W-1:0]  best_p_w;
  logic [SUM_W-1:0]  dsum_full_w;
  logic [PROB_W-1:0] conf_w;
  logic [PROB_W-1:0] dsum_w;
  logic              flag_w;
  always_comb begin
    best_w   = CLS_CUTS;
    best_p_w = p_r[0];
    for (int k = 1; k < NUM_CLASS_COUNT; k++) begin
      if (p_r[k] > best_p_w) begin
        best_w   = CLS_W'(k);
        best_p_w = p_r[k];
      end
    end
    conf_w      = best_p_w[EXP_W-1] ? '1 : best_p_w[PROB_W-1:0];
    dsum_full_w = SUM_W'(p_r[CLS_CUTS]) + SUM_W'(p_r[CLS_HOLE]) + SUM_W'(p_r[CLS_OIL]);
    dsum_w      = (|dsum_full_w[SUM_W-1:PROB_W]) ? '1 : dsum_full_w[PROB_W-1:0];
    flag_w      = (dsum_w >= thr_r) &&
                  ((best_w != CLS_LINT && best_w != CLS_NORMAL) || (conf_w < guard_r));
  end

  // control state: config, frame tracking, output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.decide) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      guard_r     <= GUARD_RST;
      flagged_r   <= 1'b0;
      last_tag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DEFECT_THRESHOLD: thr_r   <= cfg_data[PROB_W-1:0];
          REG_CONFIDENCE_GUARD: guard_r <= cfg_data[PROB_W-1:0];
          default: ;
        endcase
      end
      // a new frame tag clears the flagged mark
      if (cmd.load_in && (in_frame_tag != last_tag_r)) begin
        last_tag_r <= in_frame_tag;
        flagged_r  <= 1'b0;
      end else if (cmd.decide && flag_w) begin
        flagged_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tag_r <= in_frame_tag;
      for (int k = 0; k < NUM_CLASS_COUNT; k++) begin
        logit_r[k] <= in_logit[k];
      end
    end
    if (cmd.latch_max) begin
      mx_r  <= mx_w;
      sum_r <= '0;
    end
    // table ROM with registered read
    if (cmd.exp_rd) begin
      rom_q_r  <= EXP_TAB[rd_idx_w];
      zero_q_r <= d_big_w;
    end
    if (cmd.exp_wr) begin
      e_r[cmd.wr_cls] <= e_new_w;
      sum_r           <= sum_r + SUM_W'(e_new_w);
    end
    if (cmd.div_load) begin
      rem_r <= REM_W'(num_full_w[NUM_W-1:QUO_W]);
      num_r <= num_full_w[QUO_W-1:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= r2s_w;
      num_r <= {num_r[QUO_W-3:0], 2'b00};
      quo_r <= quo_nxt;
    end
    if (cmd.div_store) begin
      p_r[cmd.cls] <= quo_nxt[EXP_W-1:0];
    end
    if (cmd.decide) begin
      o_tag_r  <= tag_r;
      o_cls_r  <= best_w;
      o_conf_r <= conf_w;
      o_dsum_r <= dsum_w;
      o_flag_r <= flag_w;
    end
  end

  // status and result channel
  assign stat.skip     = flagged_r;
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_frame_tag = o_tag_r;
  assign out_ch.pred_class       = o_cls_r;
  assign out_ch.confidence       = o_conf_r;
  assign out_ch.defect_prob      = o_dsum_r;
  assign out_ch.defect_flag      = o_flag_r;

endmodule

[design/softmax_defect_decision_top.sv]
// A result is registered after the frame check, max search, table sweep, per-class
// division and decide states, later while the previous result waits on the result
// channel. A new region is accepted only in idle; a region of an already flagged frame
// is dropped after the frame check. The divider loads, then takes two-bit steps, per
// class. The exp table ROM is swept once per region, one class per cycle.
// Reset (rst_n low, synchronous) restores both thresholds and clears the frame state.
// ----------------------------------------------------------------------------
// softmax_defect_decision_top
// Five-class softmax with argmax and per-frame defect decision.
// ----------------------------------------------------------------------------
module softmax_defect_decision_top import sdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sdd_in_if.sink                in_ch,
  sdd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic signed [LOGIT_W-1:0] logit_w [NUM_CLASS_COUNT];

  // logits in class order
  assign logit_w[CLS_CUTS]   = in_ch.logit_cuts;
  assign logit_w[CLS_HOLE]   = in_ch.logit_hole;
  assign logit_w[CLS_LINT]   = in_ch.logit_lint;
  assign logit_w[CLS_NORMAL] = in_ch.logit_normal;
  assign logit_w[CLS_OIL]    = in_ch.logit_oil;
  assign in_ch.ready         = in_ready;

  // controller
  sdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  sdd_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_frame_tag (in_ch.frame_tag),
    .in_logit     (logit_w),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_ch       (out_ch)
  );

endmodule
